@@ src/vn_pkg.sv @@
// shared types for the vector normalizer
// the cell modules and the top level import this package
package vn_pkg;

  localparam int unsigned SqrtCells = 32;
  localparam int unsigned DivCells = 31;

  typedef struct packed {
    logic [2:0]  neg;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
  } vn_pay_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] dvd;
    logic [30:0] q;
  } vn_lane_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic [31:0] mag;
    vn_lane_t    lx;
    vn_lane_t    ly;
    vn_lane_t    lz;
  } vn_div_t;

endpackage

@@ src/vn_sqrt_cell.sv @@
// one step of the bit-serial square root: takes two radicand bits, gives one root bit
// depends on vn_pkg
module vn_sqrt_cell import vn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [63:0] rad_i,
  input  logic [33:0] rem_i,
  input  logic [31:0] root_i,
  input  vn_pay_t     pay_i,
  output logic        vld_o,
  output logic [63:0] rad_o,
  output logic [33:0] rem_o,
  output logic [31:0] root_o,
  output vn_pay_t     pay_o
);

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic        vld_r;
  logic [63:0] rad_r;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r;
  vn_pay_t     pay_r;

  always_comb begin
    rem_sh  = {rem_i, rad_i[63:62]};
    trial   = {2'b00, root_i, 2'b01};
    ge      = rem_sh >= trial;
    rem_nxt = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      rad_r  <= {rad_i[61:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_i[30:0], ge};
      pay_r  <= pay_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pay_o  = pay_r;

endmodule

@@ src/vn_div_cell.sv @@
// one restoring division step for all three components, one quotient bit each
// depends on vn_pkg
module vn_div_cell import vn_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    vld_i,
  input  vn_div_t dat_i,
  output logic    vld_o,
  output vn_div_t dat_o
);

  function automatic vn_lane_t step(vn_lane_t l, logic [31:0] d);
    logic [32:0] sh;
    logic        ge;
    vn_lane_t    r;
    sh    = {l.rem, l.dvd[30]};
    ge    = sh >= {1'b0, d};
    r.rem = ge ? 32'(sh - {1'b0, d}) : sh[31:0];
    r.dvd = {l.dvd[29:0], 1'b0};
    r.q   = {l.q[29:0], ge};
    return r;
  endfunction

  logic    vld_r;
  vn_div_t dat_r, dat_nxt;

  always_comb begin
    dat_nxt     = dat_i;
    dat_nxt.lx  = step(dat_i.lx, dat_i.mag);
    dat_nxt.ly  = step(dat_i.ly, dat_i.mag);
    dat_nxt.lz  = step(dat_i.lz, dat_i.mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

@@ src/vector3_normalize.sv @@
// vector normalizer top level: squares, square root cell chain, division cell chain
// depends on vn_pkg, vn_sqrt_cell and vn_div_cell
//
// in_tdata carries one vector per beat, out_tdata the unit vector and its length.
// a beat is taken on in_tvalid && in_tready, given on out_tvalid && out_tready.
// from input to output a beat passes through the stages: squares,
// sum, 32 square root cells (one root bit per cell), 31 division cells (one
// quotient bit per cell, three lanes), output.
// throughput is one beat per cycle unless the receiver stalls; the whole pipeline advances together.
// when the receiver stalls with a beat waiting, the pipeline holds and
// in_tready drops; it rises again the cycle the waiting beat is taken.
// reset (synchronous, rst_n low) clears all valid flags, so nothing is in flight.
// a zero vector gives length zero, zero components and out_tuser high.
module vector3_normalize import vn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // vec_x, vec_y, vec_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // unit_x, unit_y, unit_z, length
  output logic         out_tuser   // zero_error
);

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // abs, squares and their sum
  logic [31:0] cx, cy, cz;
  logic [2:0]  neg_c;
  vn_pay_t     p1_r, p2_r;
  logic [63:0] sx_r, sy_r, sz_r, sum_r;
  logic        v1_r, v2_r;

  always_comb begin
    neg_c = {in_tdata[95], in_tdata[63], in_tdata[31]};
    cx = in_tdata[31] ? 32'(-in_tdata[31:0])  : in_tdata[31:0];
    cy = in_tdata[63] ? 32'(-in_tdata[63:32]) : in_tdata[63:32];
    cz = in_tdata[95] ? 32'(-in_tdata[95:64]) : in_tdata[95:64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
    if (en) begin
      p1_r  <= '{neg: neg_c, ax: cx, ay: cy, az: cz};
      sx_r  <= cx * cx;
      sy_r  <= cy * cy;
      sz_r  <= cz * cz;
      p2_r  <= p1_r;
      sum_r <= sx_r + sy_r + sz_r;
    end
  end

  // square root chain
  logic        sv   [SqrtCells+1];
  logic [63:0] srad [SqrtCells+1];
  logic [33:0] srem [SqrtCells+1];
  logic [31:0] sroot[SqrtCells+1];
  vn_pay_t     spay [SqrtCells+1];

  assign sv[0]    = v2_r;
  assign srad[0]  = sum_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign spay[0]  = p2_r;

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .vld_i(sv[i]),   .rad_i(srad[i]),   .rem_i(srem[i]),
      .root_i(sroot[i]), .pay_i(spay[i]),
      .vld_o(sv[i+1]), .rad_o(srad[i+1]), .rem_o(srem[i+1]),
      .root_o(sroot[i+1]), .pay_o(spay[i+1])
    );
  end

  // division chain
  logic    dv[DivCells+1];
  vn_div_t dd[DivCells+1];
  vn_pay_t sp;

  assign sp = spay[SqrtCells];
  assign dv[0] = sv[SqrtCells];
  always_comb begin
    dd[0].neg    = sp.neg;
    dd[0].mag    = sroot[SqrtCells];
    dd[0].lx.rem = {1'b0, sp.ax[31:1]};
    dd[0].lx.dvd = {sp.ax[0], 30'd0};
    dd[0].lx.q   = '0;
    dd[0].ly.rem = {1'b0, sp.ay[31:1]};
    dd[0].ly.dvd = {sp.ay[0], 30'd0};
    dd[0].ly.q   = '0;
    dd[0].lz.rem = {1'b0, sp.az[31:1]};
    dd[0].lz.dvd = {sp.az[0], 30'd0};
    dd[0].lz.q   = '0;
  end

  for (genvar j = 0; j < DivCells; j++) begin : g_div
    vn_div_cell u_cell (
      .clk, .rst_n, .en,
      .vld_i(dv[j]), .dat_i(dd[j]),
      .vld_o(dv[j+1]), .dat_o(dd[j+1])
    );
  end

  // sign restore, zero-vector clearing and output register
  vn_div_t     df;
  logic        zero;
  logic [31:0] ux, uy, uz;
  logic        out_valid_r;
  logic [127:0] out_data_r;
  logic        out_user_r;

  assign df   = dd[DivCells];
  assign zero = df.mag == '0;

  always_comb begin
    ux = df.neg[0] ? 32'(-{1'b0, df.lx.q}) : {1'b0, df.lx.q};
    uy = df.neg[1] ? 32'(-{1'b0, df.ly.q}) : {1'b0, df.ly.q};
    uz = df.neg[2] ? 32'(-{1'b0, df.lz.q}) : {1'b0, df.lz.q};
    if (zero) begin
      ux = '0;
      uy = '0;
      uz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[DivCells];
    end
    if (en) begin
      out_data_r <= {df.mag, uz, uy, ux};
      out_user_r <= zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ verif/vector3_normalize_checker.sv @@
`timescale 1ns / 1ps
// checker for vector3_normalize: watches both streams, predicts each unit vector
// and length from the accepted input beat, compares field by field; needs nothing else
module vector3_normalize_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [95:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic [31:0] len;
    logic        zero_err;
  } unit_vec_t;

  unit_vec_t unit_queue[$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] scale_comp(logic [31:0] c, logic [63:0] mag);
    logic        neg;
    logic [63:0] a;
    logic [63:0] q;
    neg = c[31];
    a = neg ? (64'd0 - {{32{1'b1}}, c}) : {32'd0, c};
    q = (a << 30) / mag;
    if (neg) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic unit_vec_t normalize(logic [95:0] v);
    unit_vec_t   r;
    logic [63:0] ax, ay, az, mag;
    ax = v[31] ? 64'd0 - {{32{1'b1}}, v[31:0]} : {32'd0, v[31:0]};
    ay = v[63] ? 64'd0 - {{32{1'b1}}, v[63:32]} : {32'd0, v[63:32]};
    az = v[95] ? 64'd0 - {{32{1'b1}}, v[95:64]} : {32'd0, v[95:64]};
    mag = floor_sqrt(ax * ax + ay * ay + az * az);
    r = '0;
    if (mag == 0) begin
      r.zero_err = 1'b1;
    end else begin
      r.ux = scale_comp(v[31:0], mag);
      r.uy = scale_comp(v[63:32], mag);
      r.uz = scale_comp(v[95:64], mag);
      r.len = mag[31:0];
    end
    return r;
  endfunction

  assign pending = unit_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    unit_vec_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) unit_queue.push_back(normalize(in_tdata));
      if (out_tvalid && out_tready) begin
        if (unit_queue.size() == 0) begin
          $error("unexpected output beat %h", out_tdata);
          fail_count++;
        end else begin
          e = unit_queue.pop_front();
          if (out_tdata[31:0] !== e.ux) begin
            $error("unit_x expected %h got %h", e.ux, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[63:32] !== e.uy) begin
            $error("unit_y expected %h got %h", e.uy, out_tdata[63:32]);
            fail_count++;
          end
          if (out_tdata[95:64] !== e.uz) begin
            $error("unit_z expected %h got %h", e.uz, out_tdata[95:64]);
            fail_count++;
          end
          if (out_tdata[127:96] !== e.len) begin
            $error("length expected %h got %h", e.len, out_tdata[127:96]);
            fail_count++;
          end
          if (out_tuser !== e.zero_err) begin
            $error("zero_error expected %b got %b", e.zero_err, out_tuser);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ verif/vector3_normalize_tb.sv @@
`timescale 1ns / 1ps
// top of the vector3_normalize testbench: clock, reset, bursty vector stimulus
// and a stalling receiver; the checker module does prediction and comparison
module vector3_normalize_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         out_tuser;
  int           fail_count;
  int           pending;
  int           cycles;
  logic         hold_off;
  logic         stim_done;

  vector3_normalize dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  vector3_normalize_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 15) - 8;
      4: return $urandom_range(0, 'h3ffff) - 'h20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // receiver: random stall pattern, one long hold-off early on
  initial begin
    int mode;
    out_tready = 1'b0;
    hold_off = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    repeat (20) @(negedge clk);
    hold_off = 1'b1;
    out_tready <= 1'b0;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= $urandom_range(0, 4) != 0;
          default: out_tready <= $urandom_range(0, 4) == 0;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [31:0] ext [4];
    int burst;
    ext[0] = 32'h8000_0000;
    ext[1] = 32'h7fff_ffff;
    ext[2] = 32'd0;
    ext[3] = 32'h0000_0001;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    stim_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // zero vector, single-axis extremes, all-extreme corners, fixed mixed patterns
    send_vec(0, 0, 0);
    for (int i = 0; i < 4; i++) begin
      send_vec(ext[i], 0, 0);
      send_vec(0, ext[i], 0);
      send_vec(0, 0, ext[i]);
    end
    send_vec(ext[0], ext[0], ext[0]);
    send_vec(ext[1], ext[1], ext[1]);
    send_vec(ext[0], ext[1], ext[0]);
    send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vec(32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    while (hold_off) send_vec(rand_comp(), rand_comp(), rand_comp());
    for (int n = 0; n < 900; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        send_vec(rand_comp(), rand_comp(), rand_comp());
        n++;
      end
      send_gap();
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
